/* design/stpt_pkg.sv */
// shared constants, verdict codes and sequencer state types for the prime tester
`timescale 1ns / 1ps

package stpt_pkg;

  localparam int unsigned SIEVE_LIMIT_DEF = 65536;
  localparam int unsigned PRIME_SLOTS_DEF = 8192;

  // width of the tested number
  localparam int unsigned NUM_W = 32;
  localparam int unsigned VERDICT_W = 2;

  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam verdict_t VERDICT_COMPOSITE = 2'd0;
  localparam verdict_t VERDICT_PRIME     = 2'd1;
  localparam verdict_t VERDICT_UNDECIDED = 2'd2;

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_OUTER_RD,
    SV_OUTER_CHK,
    SV_MARK,
    SV_SCAN_RD,
    SV_SCAN_CHK,
    SV_DONE
  } sieve_state_t;

  typedef enum logic [2:0] {
    TS_INIT,
    TS_IDLE,
    TS_READ,
    TS_LOAD,
    TS_DIV
  } test_state_t;

endpackage

/* design/stpt_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module stpt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/stpt_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module stpt_div #(
  parameter int unsigned DW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [stpt_pkg::NUM_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       busy,
  output logic                       done,
  output logic [stpt_pkg::NUM_W-1:0] quotient,
  output logic [DW-1:0]              remainder
);

  localparam int unsigned NW    = stpt_pkg::NUM_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    acc;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             fin;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  // partial remainder stays below the divisor, so the difference fits in DW bits
  always_comb begin
    trial    = {rem, acc[NW-1]};
    diff     = trial - {1'b0, dvs};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      cnt     <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        acc     <= dividend;
        rem     <= '0;
        dvs     <= divisor;
        cnt     <= CNT_W'(NW);
        running <= 1'b1;
      end else if (running) begin
        rem <= rem_next;
        acc <= {acc[NW-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

  assign busy      = running;
  assign done      = fin;
  assign quotient  = acc;
  assign remainder = rem;

endmodule

/* design/stpt_sieve.sv */
// sieve sequencer: clears the composite map, marks multiples, packs primes into the table
`timescale 1ns / 1ps

module stpt_sieve #(
  parameter int unsigned SIEVE_LIMIT = stpt_pkg::SIEVE_LIMIT_DEF,
  parameter int unsigned PRIME_SLOTS = stpt_pkg::PRIME_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  output logic                               tbl_we,
  output logic [$clog2(PRIME_SLOTS)-1:0]     tbl_addr,
  output logic [$clog2(SIEVE_LIMIT)-1:0]     tbl_data,
  output logic                               done,
  output logic [$clog2(PRIME_SLOTS+1)-1:0]   prime_count
);

  localparam int unsigned AW  = $clog2(SIEVE_LIMIT);
  localparam int unsigned IW  = AW + 1;
  localparam int unsigned TAW = $clog2(PRIME_SLOTS);
  localparam int unsigned CW  = $clog2(PRIME_SLOTS + 1);

  stpt_pkg::sieve_state_t state, state_next;

  logic [IW-1:0] i;
  logic [IW-1:0] isq;
  logic [IW-1:0] j;
  logic [CW-1:0] count;

  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic          map_re;
  logic [AW-1:0] map_raddr;
  logic          map_rdata;

  logic          clear_last;
  logic          outer_end;
  logic          mark_end;
  logic          scan_end;
  logic [IW-1:0] isq_adv;

  stpt_ram #(
    .WIDTH(1),
    .DEPTH(SIEVE_LIMIT)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .re   (map_re),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  always_comb begin
    clear_last = i == IW'(SIEVE_LIMIT - 1);
    outer_end  = isq >= IW'(SIEVE_LIMIT);
    mark_end   = j >= IW'(SIEVE_LIMIT);
    scan_end   = (i >= IW'(SIEVE_LIMIT)) || (count == CW'(PRIME_SLOTS));
    // (i+1)^2 = i^2 + 2i + 1
    isq_adv    = isq + {i[IW-2:0], 1'b0} + IW'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      stpt_pkg::SV_CLEAR: begin
        if (clear_last) state_next = stpt_pkg::SV_OUTER_RD;
      end
      stpt_pkg::SV_OUTER_RD: begin
        state_next = outer_end ? stpt_pkg::SV_SCAN_RD : stpt_pkg::SV_OUTER_CHK;
      end
      stpt_pkg::SV_OUTER_CHK: begin
        state_next = map_rdata ? stpt_pkg::SV_OUTER_RD : stpt_pkg::SV_MARK;
      end
      stpt_pkg::SV_MARK: begin
        if (mark_end) state_next = stpt_pkg::SV_OUTER_RD;
      end
      stpt_pkg::SV_SCAN_RD: begin
        state_next = scan_end ? stpt_pkg::SV_DONE : stpt_pkg::SV_SCAN_CHK;
      end
      stpt_pkg::SV_SCAN_CHK: begin
        state_next = stpt_pkg::SV_SCAN_RD;
      end
      stpt_pkg::SV_DONE: begin
        state_next = stpt_pkg::SV_DONE;
      end
      default: begin
        state_next = stpt_pkg::SV_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    map_we    = 1'b0;
    map_waddr = i[AW-1:0];
    map_wdata = 1'b0;
    map_re    = 1'b0;
    map_raddr = i[AW-1:0];
    tbl_we    = 1'b0;
    unique case (state)
      stpt_pkg::SV_CLEAR: begin
        map_we = 1'b1;
      end
      stpt_pkg::SV_OUTER_RD: begin
        map_re = !outer_end;
      end
      stpt_pkg::SV_MARK: begin
        map_we    = !mark_end;
        map_waddr = j[AW-1:0];
        map_wdata = 1'b1;
      end
      stpt_pkg::SV_SCAN_RD: begin
        map_re = !scan_end;
      end
      stpt_pkg::SV_SCAN_CHK: begin
        tbl_we = !map_rdata;
      end
      default: begin
      end
    endcase
  end

  assign tbl_addr    = count[TAW-1:0];
  assign tbl_data    = i[AW-1:0];
  assign done        = state == stpt_pkg::SV_DONE;
  assign prime_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stpt_pkg::SV_CLEAR;
      i     <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        stpt_pkg::SV_CLEAR: begin
          if (clear_last) begin
            i   <= IW'(2);
            isq <= IW'(4);
          end else begin
            i <= i + IW'(1);
          end
        end
        stpt_pkg::SV_OUTER_RD: begin
          if (outer_end) i <= IW'(2);
        end
        stpt_pkg::SV_OUTER_CHK: begin
          if (map_rdata) begin
            i   <= i + IW'(1);
            isq <= isq_adv;
          end else begin
            j <= isq;
          end
        end
        stpt_pkg::SV_MARK: begin
          if (mark_end) begin
            i   <= i + IW'(1);
            isq <= isq_adv;
          end else begin
            j <= j + i;
          end
        end
        stpt_pkg::SV_SCAN_CHK: begin
          if (!map_rdata) count <= count + CW'(1);
          i <= i + IW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/sieve_and_trial_division_prime_test.sv */
// top level: sieve-built prime table walked by trial division with a single divider
//
//  channel  | ports                  | direction | handshake
//  ---------+------------------------+-----------+--------------------------------------
//  input    | start, busy, number    | in / out  | beat taken when start && !busy
//  result   | done, verdict          | out       | one-cycle strobe, cannot be held off
//
// after reset the block is busy while it builds its tables: it clears the composite
//   map, reads each sieve candidate and marks its multiples, and then scans every value
//   to pack the prime table
// numbers 0, 1 and 2 answer in the cycle after the beat
// any other number walks the table; each tried prime takes a table read, a divider load
//   and 32 divider steps; the walk stops at the first dividing prime, the first prime
//   whose square exceeds the number or the end of the table, so small factors exit early
// the receiver cannot stall; busy alone paces the input side
`timescale 1ns / 1ps

module sieve_and_trial_division_prime_test #(
  parameter int unsigned SIEVE_LIMIT = stpt_pkg::SIEVE_LIMIT_DEF,
  parameter int unsigned PRIME_SLOTS = stpt_pkg::PRIME_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [stpt_pkg::NUM_W-1:0]       number,
  output logic                             done,
  output logic [stpt_pkg::VERDICT_W-1:0]   verdict
);

  localparam int unsigned NW  = stpt_pkg::NUM_W;
  localparam int unsigned AW  = $clog2(SIEVE_LIMIT);
  localparam int unsigned TAW = $clog2(PRIME_SLOTS);
  localparam int unsigned CW  = $clog2(PRIME_SLOTS + 1);

  stpt_pkg::test_state_t state, state_next;

  // latched operand and table walk index
  logic [NW-1:0] n;
  logic [CW-1:0] k;
  logic          res_valid;
  stpt_pkg::verdict_t res_verdict;

  // sieve to table write side
  logic           sv_tbl_we;
  logic [TAW-1:0] sv_tbl_addr;
  logic [AW-1:0]  sv_tbl_data;
  logic           sieve_done;
  logic [CW-1:0]  prime_count;

  // table read side: data holds between reads, so it doubles as the current prime
  logic           tbl_re;
  logic [AW-1:0]  prime;

  logic           div_start;
  logic           div_busy;
  logic           div_done;
  logic [NW-1:0]  quo;
  logic [AW-1:0]  rem;

  logic           accept;
  logic           num_low;
  logic           num_two;
  logic           divides;
  logic           past_root;
  logic           table_out;

  stpt_sieve #(
    .SIEVE_LIMIT(SIEVE_LIMIT),
    .PRIME_SLOTS(PRIME_SLOTS)
  ) u_sieve (
    .clk        (clk),
    .rst        (rst),
    .tbl_we     (sv_tbl_we),
    .tbl_addr   (sv_tbl_addr),
    .tbl_data   (sv_tbl_data),
    .done       (sieve_done),
    .prime_count(prime_count)
  );

  stpt_ram #(
    .WIDTH(AW),
    .DEPTH(PRIME_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (sv_tbl_we),
    .waddr(sv_tbl_addr),
    .wdata(sv_tbl_data),
    .re   (tbl_re),
    .raddr(k[TAW-1:0]),
    .rdata(prime)
  );

  stpt_div #(
    .DW(AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (prime),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  always_comb begin
    accept    = start && !busy;
    num_low   = number < NW'(2);
    num_two   = number == NW'(2);
    divides   = rem == '0;
    // floor(n / p) < p exactly when p * p > n
    past_root = quo < NW'(prime);
    table_out = (k + CW'(1)) == prime_count;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      stpt_pkg::TS_INIT: begin
        if (sieve_done) state_next = stpt_pkg::TS_IDLE;
      end
      stpt_pkg::TS_IDLE: begin
        if (start && !num_low && !num_two) state_next = stpt_pkg::TS_READ;
      end
      stpt_pkg::TS_READ: begin
        state_next = stpt_pkg::TS_LOAD;
      end
      stpt_pkg::TS_LOAD: begin
        state_next = stpt_pkg::TS_DIV;
      end
      stpt_pkg::TS_DIV: begin
        if (div_done) begin
          state_next = (divides || past_root || table_out) ? stpt_pkg::TS_IDLE
                                                           : stpt_pkg::TS_READ;
        end
      end
      default: begin
        state_next = stpt_pkg::TS_INIT;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b1;
    tbl_re    = 1'b0;
    div_start = 1'b0;
    unique case (state)
      stpt_pkg::TS_IDLE: busy      = 1'b0;
      stpt_pkg::TS_READ: tbl_re    = 1'b1;
      stpt_pkg::TS_LOAD: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stpt_pkg::TS_INIT;
      res_valid <= 1'b0;
      k         <= '0;
    end else begin
      state     <= state_next;
      res_valid <= 1'b0;
      priority if (accept) begin
        n <= number;
        k <= '0;
        if (num_low) begin
          res_valid   <= 1'b1;
          res_verdict <= stpt_pkg::VERDICT_COMPOSITE;
        end else if (num_two) begin
          res_valid   <= 1'b1;
          res_verdict <= stpt_pkg::VERDICT_PRIME;
        end
      end else if (state == stpt_pkg::TS_DIV && div_done) begin
        // divisibility is checked before the square bound
        priority if (divides) begin
          res_valid   <= 1'b1;
          res_verdict <= stpt_pkg::VERDICT_COMPOSITE;
        end else if (past_root) begin
          res_valid   <= 1'b1;
          res_verdict <= stpt_pkg::VERDICT_PRIME;
        end else if (table_out) begin
          res_valid   <= 1'b1;
          res_verdict <= stpt_pkg::VERDICT_UNDECIDED;
        end else begin
          k <= k + CW'(1);
        end
      end else begin
      end
    end
  end

  assign done    = res_valid;
  assign verdict = res_verdict;

  // small numbers answer on the very next cycle
  a_low_composite: assert property (@(posedge clk) disable iff (rst)
    start && !busy && number < NW'(2) |=> done && verdict == stpt_pkg::VERDICT_COMPOSITE)
    else $error("number below two not reported composite");

  a_two_prime: assert property (@(posedge clk) disable iff (rst)
    start && !busy && number == NW'(2) |=> done && verdict == stpt_pkg::VERDICT_PRIME)
    else $error("two not reported prime");

  // no beat is taken before the prime table is complete
  a_busy_during_sieve: assert property (@(posedge clk) disable iff (rst)
    !sieve_done |-> busy)
    else $error("ready while the sieve is still running");

  // the divider only runs inside a table walk
  a_div_in_walk: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == stpt_pkg::TS_DIV)
    else $error("divider active outside the walk");

endmodule

/* tb/tb_sieve_and_trial_division_prime_test.sv */
// testbench for the sieve-built trial-division prime tester: directed and random numbers
`timescale 1ns / 1ps

module tb_sieve_and_trial_division_prime_test;
  import stpt_pkg::*;

  localparam int unsigned SIEVE_LIMIT = SIEVE_LIMIT_DEF;
  localparam int unsigned PRIME_SLOTS = PRIME_SLOTS_DEF;

  // the longest quiet stretch of a good run is the table build after reset
  // (clear, sieve and pack) or the walk of one number over the whole table of
  // about 6.5k primes
  localparam int unsigned WATCHDOG_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned IDLE_PERCENT = 20;
  // beats in this window are sent back to back, with no idle cycles at all
  localparam int unsigned STEADY_FIRST = 50;
  localparam int unsigned STEADY_LAST = 100;
  localparam int unsigned RANDOM_ITEMS = 117;

  typedef struct {
    logic [NUM_W-1:0] number;
    verdict_t         verdict;
  } tested_number_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [NUM_W-1:0]     number = '0;
  logic                 busy;
  logic                 done;
  logic [VERDICT_W-1:0] verdict;

  // local copy of the prime table, built the same way the block builds its own
  bit          is_composite [SIEVE_LIMIT];
  int unsigned table_primes [PRIME_SLOTS];
  int unsigned prime_total = 0;

  logic [NUM_W-1:0] numbers_to_test [$];   // beats not yet sent
  tested_number_t   expected_verdicts [$]; // sent beats waiting for their result
  tested_number_t   oldest_test;

  int unsigned beats_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  sieve_and_trial_division_prime_test dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .number  (number),
    .done    (done),
    .verdict (verdict)
  );

  always #6 clk = ~clk;

  // trial division over the local table: a dividing prime means composite,
  // a prime whose square passes the number means prime, running out is undecided
  function automatic verdict_t primality_verdict(logic [NUM_W-1:0] n);
    logic [63:0] wide_n;
    logic [63:0] p;
    wide_n = {32'd0, n};
    if (n < 2) return VERDICT_COMPOSITE;
    if (n == 2) return VERDICT_PRIME;
    for (int unsigned k = 0; k < prime_total; k++) begin
      p = table_primes[k];
      if (wide_n % p == 0) return VERDICT_COMPOSITE;
      if (p * p > wide_n) return VERDICT_PRIME;
    end
    return VERDICT_UNDECIDED;
  endfunction

  task automatic note_mismatch(string what, logic [NUM_W-1:0] n, verdict_t want, verdict_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: number %0d expected verdict %0d, got %0d",
               $realtime, what, n, want, got);
  endtask

  // driver: a beat is held until start && !busy, then the next one is loaded
  // or start drops for a random idle cycle; during idle the number is noise
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      number <= '0;
    end else begin
      if (start && !busy) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 tested_number_t'{number, primality_verdict(number)});
        beats_sent++;
      end
      if (!(start && busy)) begin
        if (numbers_to_test.size() != 0 &&
            !((beats_sent < STEADY_FIRST || beats_sent >= STEADY_LAST) &&
              $urandom_range(0, 99) < IDLE_PERCENT)) begin
          start <= 1'b1;
          number <= numbers_to_test.pop_front();
        end else begin
          start <= 1'b0;
          number <= $urandom();
        end
      end
    end
  end

  // monitor: every done strobe is one result beat, matched in order
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch("result with no beat pending", '0, VERDICT_COMPOSITE, verdict);
      end else begin
        oldest_test = expected_verdicts.pop_front();
        if (verdict !== oldest_test.verdict)
          note_mismatch("wrong verdict", oldest_test.number, oldest_test.verdict, verdict);
      end
    end
  end

  // watchdog: ends the run after too long with neither an input nor a result beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned a;
    int unsigned b;

    // sieve of eratosthenes, then pack the primes in ascending order
    is_composite[0] = 1'b1;
    is_composite[1] = 1'b1;
    for (int unsigned i = 2; i * i < SIEVE_LIMIT; i++)
      if (!is_composite[i])
        for (int unsigned j = i * i; j < SIEVE_LIMIT; j += i)
          is_composite[j] = 1'b1;
    for (int unsigned i = 2; i < SIEVE_LIMIT && prime_total < PRIME_SLOTS; i++)
      if (!is_composite[i]) begin
        table_primes[prime_total] = i;
        prime_total++;
      end

    // directed: below two, exactly two, small primes and prime squares,
    // the largest table prime, values just past the sieve limit, the top of
    // the range, and a prime above the square of the largest table prime,
    // which exhausts the table and comes back undecided
    numbers_to_test = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9,
                        32'd15, 32'd25, 32'd49, 32'd121, 32'd65521, 32'd65536,
                        32'd65537, 32'd999999, 32'd1000003, 32'd1052651,
                        32'd2147483648, 32'd4293001442, 32'd4294967294,
                        32'd4294967295, 32'd4294967291};

    // random: mostly small numbers so the walk stays short, some medium ones,
    // products of table primes that sit on the square boundary, and a few
    // full-width values
    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        numbers_to_test.insert(numbers_to_test.size(), $urandom());
      end else if (pick < 25) begin
        numbers_to_test.insert(numbers_to_test.size(), $urandom_range(0, (1 << 20) - 1));
      end else if (pick < 35) begin
        numbers_to_test.insert(numbers_to_test.size(), $urandom_range(0, 16));
      end else if (pick < 50) begin
        a = table_primes[$urandom_range(0, 199)];
        b = ($urandom_range(0, 1) == 0) ? a : table_primes[$urandom_range(0, 199)];
        numbers_to_test.insert(numbers_to_test.size(), a * b);
      end else begin
        numbers_to_test.insert(numbers_to_test.size(), $urandom_range(0, SIEVE_LIMIT - 1));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // poll away from the active edge so queue updates have settled
    while (numbers_to_test.size() != 0 || start || expected_verdicts.size() != 0)
      @(negedge clk);
    // a short drain to catch a stray extra result
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
